// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk with rst_n as disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ULPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ULPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/ulpm_pkg.sv =====
// ----------------------------------------------------------------------------
// ulpm_pkg
// shared constants, types and command/status structs of the line position mapper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ulpm_pkg;

  localparam int MAX_LINE_BYTES = 4096;

  // fixed port widths
  localparam int ACT_W  = 2;
  localparam int BYTE_W = 8;
  localparam int QPOS_W = 16;
  localparam int POS_W  = 13;

  // derived storage and counter widths
  localparam int PT_W      = $clog2(MAX_LINE_BYTES + 1);
  localparam int CNT_W     = $clog2(MAX_LINE_BYTES + 2);
  localparam int BCNT_W    = $clog2(MAX_LINE_BYTES + 1);
  localparam int P2U_DEPTH = MAX_LINE_BYTES;
  localparam int U2P_DEPTH = MAX_LINE_BYTES + 1;
  localparam int P2U_AW    = $clog2(P2U_DEPTH);
  localparam int U2P_AW    = $clog2(U2P_DEPTH);
  localparam int CMP_W     = (CNT_W > QPOS_W - 1) ? CNT_W : QPOS_W - 1;

  localparam logic [ACT_W-1:0] ACT_NEW_LINE      = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BYTE          = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POINT_TO_UNIT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_UNIT_TO_POINT = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE2,
    ST_READ
  } state_t;

  typedef struct packed {
    logic new_line;
    logic take_byte;
    logic take_query;
    logic second_write;
    logic load_out;
  } ulpm_cmd_t;

  typedef struct packed {
    logic four_lead;
  } ulpm_stat_t;

endpackage

// ===== sv/ulpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ulpm_ctrl
// controller: sequences byte writes, table reads and the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ulpm_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [ulpm_pkg::ACT_W-1:0] in_action,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  ulpm_pkg::ulpm_stat_t      stat,
  output ulpm_pkg::ulpm_cmd_t       cmd
);
  import ulpm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   is_query;

  assign accept   = in_valid && !in_stall;
  assign is_query = (in_action == ACT_POINT_TO_UNIT) || (in_action == ACT_UNIT_TO_POINT);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_nxt = ST_READ;
        end else if (accept && (in_action == ACT_BYTE) && stat.four_lead) begin
          state_nxt = ST_WRITE2;
        end
      end
      ST_WRITE2: begin
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall         = (state_r != ST_IDLE);
    cmd.new_line     = accept && (in_action == ACT_NEW_LINE);
    cmd.take_byte    = accept && (in_action == ACT_BYTE);
    cmd.take_query   = accept && is_query;
    cmd.second_write = (state_r == ST_WRITE2);
    cmd.load_out     = (state_r == ST_READ) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/ulpm_dp.sv =====
// ----------------------------------------------------------------------------
// ulpm_dp
// datapath: line counters, the two position tables and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ulpm_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ulpm_pkg::ulpm_cmd_t         cmd,
  input  logic [ulpm_pkg::ACT_W-1:0]  in_action,
  input  logic [ulpm_pkg::BYTE_W-1:0] in_text_byte,
  input  logic signed [ulpm_pkg::QPOS_W-1:0] in_query_position,
  output ulpm_pkg::ulpm_stat_t        stat,
  output logic [ulpm_pkg::POS_W-1:0]  out_converted_position,
  output logic                        out_line_overflowed
);
  import ulpm_pkg::*;

  logic [PT_W-1:0]   point_total_r, point_total_nxt;
  logic [CNT_W-1:0]  unit_total_r, unit_total_nxt;
  logic [BCNT_W-1:0] byte_total_r, byte_total_nxt;
  logic [1:0]        skip_r, skip_nxt;
  logic              ovf_r, ovf_nxt;

  logic [U2P_AW-1:0] w2_addr_r;
  logic [PT_W-1:0]   w2_data_r;

  logic [CNT_W-1:0]  p2u_mem [P2U_DEPTH];
  logic [PT_W-1:0]   u2p_mem [U2P_DEPTH];
  logic [CNT_W-1:0]  p2u_rd_r;
  logic [PT_W-1:0]   u2p_rd_r;

  logic              q_to_unit_r, q_neg_r, q_clamp_r, q_zero_r;
  logic [POS_W-1:0]  res_r;
  logic              res_ovf_r;

  logic              byte_full, do_byte, do_lead;
  logic [1:0]        lead_skip;
  logic [1:0]        lead_units;
  logic [PT_W-1:0]   new_point;
  logic [CNT_W-1:0]  new_units;

  logic              u2p_we;
  logic [U2P_AW-1:0] u2p_waddr;
  logic [PT_W-1:0]   u2p_wdata;
  logic              p2u_we;

  logic [CMP_W-1:0]  pos_ext, limit_ext;
  logic              to_unit;
  logic [POS_W-1:0]  res_val;

  // lead byte classification
  always_comb begin
    lead_skip  = 2'd0;
    lead_units = 2'd1;
    case (in_text_byte) inside
      [8'h00:8'h7F]: lead_skip = 2'd0;
      [8'hC0:8'hDF]: lead_skip = 2'd1;
      [8'hE0:8'hEF]: lead_skip = 2'd2;
      [8'hF0:8'hF7]: begin
        lead_skip  = 2'd3;
        lead_units = 2'd2;
      end
      default: lead_skip = 2'd0;
    endcase
  end

  assign byte_full      = (byte_total_r == BCNT_W'(MAX_LINE_BYTES));
  assign do_byte        = cmd.take_byte && !byte_full;
  assign do_lead        = do_byte && (skip_r == 2'd0);
  assign stat.four_lead = !byte_full && (skip_r == 2'd0) && (lead_units == 2'd2);
  assign new_point      = point_total_r + PT_W'(1);
  assign new_units      = unit_total_r + CNT_W'(lead_units);

  // counters
  always_comb begin
    point_total_nxt = point_total_r;
    unit_total_nxt  = unit_total_r;
    byte_total_nxt  = byte_total_r;
    skip_nxt        = skip_r;
    ovf_nxt         = ovf_r;
    if (cmd.new_line) begin
      point_total_nxt = '0;
      unit_total_nxt  = '0;
      byte_total_nxt  = '0;
      skip_nxt        = 2'd0;
      ovf_nxt         = 1'b0;
    end else if (cmd.take_byte && byte_full) begin
      ovf_nxt = 1'b1;
    end else if (do_byte) begin
      byte_total_nxt = byte_total_r + BCNT_W'(1);
      if (skip_r != 2'd0) begin
        skip_nxt = skip_r - 2'd1;
      end else begin
        skip_nxt        = lead_skip;
        point_total_nxt = new_point;
        unit_total_nxt  = new_units;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_total_r <= '0;
      unit_total_r  <= '0;
      byte_total_r  <= '0;
      skip_r        <= 2'd0;
      ovf_r         <= 1'b0;
    end else begin
      point_total_r <= point_total_nxt;
      unit_total_r  <= unit_total_nxt;
      byte_total_r  <= byte_total_nxt;
      skip_r        <= skip_nxt;
      ovf_r         <= ovf_nxt;
    end
  end

  // pending second unit slot of a four-byte lead
  always_ff @(posedge clk) begin
    if (do_lead) begin
      w2_addr_r <= U2P_AW'(unit_total_r + CNT_W'(1));
      w2_data_r <= point_total_r;
    end
  end

  assign u2p_we    = do_lead || cmd.second_write;
  assign u2p_waddr = cmd.second_write ? w2_addr_r : unit_total_r[U2P_AW-1:0];
  assign u2p_wdata = cmd.second_write ? w2_data_r : point_total_r;
  assign p2u_we    = do_lead && (new_point < PT_W'(P2U_DEPTH));

  // query decode
  assign to_unit   = (in_action == ACT_POINT_TO_UNIT);
  assign pos_ext   = CMP_W'(in_query_position[QPOS_W-2:0]);
  assign limit_ext = to_unit ? CMP_W'(point_total_r) : CMP_W'(unit_total_r);

  always_ff @(posedge clk) begin
    if (p2u_we) begin
      p2u_mem[new_point[P2U_AW-1:0]] <= new_units;
    end
    if (cmd.take_query && to_unit) begin
      p2u_rd_r <= p2u_mem[pos_ext[P2U_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (u2p_we) begin
      u2p_mem[u2p_waddr] <= u2p_wdata;
    end
    if (cmd.take_query && !to_unit) begin
      u2p_rd_r <= u2p_mem[pos_ext[U2P_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_query) begin
      q_to_unit_r <= to_unit;
      q_neg_r     <= in_query_position[QPOS_W-1];
      q_clamp_r   <= (pos_ext >= limit_ext);
      q_zero_r    <= (pos_ext == '0);
    end
  end

  // result select
  always_comb begin
    if (q_neg_r) begin
      res_val = '0;
    end else if (q_clamp_r) begin
      res_val = q_to_unit_r ? POS_W'(unit_total_r) : POS_W'(point_total_r);
    end else if (q_to_unit_r) begin
      res_val = q_zero_r ? '0 : POS_W'(p2u_rd_r);
    end else begin
      res_val = POS_W'(u2p_rd_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_r     <= res_val;
      res_ovf_r <= ovf_r;
    end
  end

  assign out_converted_position = res_r;
  assign out_line_overflowed    = res_ovf_r;

endmodule

// ===== sv/utf8_line_position_mapper.sv =====
// ----------------------------------------------------------------------------
// utf8_line_position_mapper: utf-8 line to utf-16 position tables and queries
// bytes and new-line beats are taken without a stall; a four-byte lead stalls for its second u2p write
// a query registers its table read, then loads the result register while the input stalls
// a stalled result beat holds a following query, and with it the input, until taken
// synchronous active-low reset clears counters and control; tables need no clearing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_line_position_mapper (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ulpm_pkg::ACT_W-1:0]         in_action,
  input  logic [ulpm_pkg::BYTE_W-1:0]        in_text_byte,
  input  logic signed [ulpm_pkg::QPOS_W-1:0] in_query_position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ulpm_pkg::POS_W-1:0]         out_converted_position,
  output logic                               out_line_overflowed
);
  import ulpm_pkg::*;

`include "assert_macros.svh"

  ulpm_cmd_t  cmd;
  ulpm_stat_t stat;

  ulpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ulpm_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .in_action              (in_action),
    .in_text_byte           (in_text_byte),
    .in_query_position      (in_query_position),
    .stat                   (stat),
    .out_converted_position (out_converted_position),
    .out_line_overflowed    (out_line_overflowed)
  );

  `ULPM_ASSERT_NEXT(a_query_busy, cmd.take_query, in_stall)
  `ULPM_ASSERT_NEXT(a_four_lead_busy, cmd.take_byte && stat.four_lead, in_stall)
  `ULPM_ASSERT_NOW(a_load_no_clobber, cmd.load_out, !out_valid || !out_stall)
  `ULPM_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid)

endmodule

// ===== test/line_position_checker.sv =====
// ----------------------------------------------------------------------------
// line_position_checker
// Watches both channels of the UTF-8 line position mapper. Every accepted byte
// or new-line beat updates a local copy of the line tables. Every lookup beat
// pushes the answer it should produce. Each accepted result beat is compared
// with the oldest pending answer. The checker reports the failure count and the
// number of answers still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_position_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_text_byte,
  input  logic [15:0] in_query_position,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [12:0] out_converted_position,
  input  logic        out_line_overflowed,
  output int          error_count,
  output int          pending_count,
  output int          lookup_count,
  output int          overflow_lookups
);
  import ulpm_pkg::*;

  localparam int LINE_CAP = MAX_LINE_BYTES;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_TAG   = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_TAG   = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_TAG   = 8'hF0;

  typedef struct {
    logic [12:0] pos;
    logic        ovf;
  } lookup_answer_t;

  logic [12:0]    point_units [0:LINE_CAP];
  logic [12:0]    unit_points [0:LINE_CAP+1];
  int unsigned    points_seen;
  int unsigned    units_seen;
  int unsigned    tail_bytes;
  int unsigned    bytes_seen;
  logic           line_dropped;
  lookup_answer_t answer_q[$];
  int             err_tally;
  int             lookups;
  int             ovf_lookups;

  assign error_count      = err_tally;
  assign lookup_count     = lookups;
  assign overflow_lookups = ovf_lookups;

  initial begin
    err_tally     = 0;
    lookups       = 0;
    ovf_lookups   = 0;
    pending_count = 0;
  end

  task automatic clear_line();
    point_units[0] = '0;
    points_seen    = 0;
    units_seen     = 0;
    tail_bytes     = 0;
    bytes_seen     = 0;
    line_dropped   = 1'b0;
  endtask

  task automatic absorb_text_byte(input logic [7:0] c);
    int unsigned units;
    int unsigned skip;
    units = 1;
    skip  = 0;
    if (bytes_seen >= LINE_CAP) begin
      line_dropped = 1'b1;
      return;
    end
    bytes_seen++;
    if (tail_bytes != 0) begin
      tail_bytes--;
      return;
    end
    if (c < ASCII_LIMIT) begin
      skip = 0;
    end else if ((c & LEAD2_MASK) == LEAD2_TAG) begin
      skip = 1;
    end else if ((c & LEAD3_MASK) == LEAD3_TAG) begin
      skip = 2;
    end else if ((c & LEAD4_MASK) == LEAD4_TAG) begin
      skip  = 3;
      units = 2;
    end
    for (int unsigned u = 0; u < units; u++) begin
      if (units_seen + u <= LINE_CAP + 1) unit_points[units_seen + u] = 13'(points_seen);
    end
    units_seen += units;
    points_seen++;
    if (points_seen <= LINE_CAP) point_units[points_seen] = 13'(units_seen);
    tail_bytes = skip;
  endtask

  function automatic logic [12:0] convert_position(input bit to_unit, input logic [15:0] raw);
    int unsigned pos;
    int unsigned lim;
    pos = raw;
    lim = to_unit ? points_seen : units_seen;
    if (raw[15]) return '0;
    if (pos >= lim) return to_unit ? 13'(units_seen) : 13'(points_seen);
    return to_unit ? point_units[pos] : unit_points[pos];
  endfunction

  always @(posedge clk) begin
    lookup_answer_t want;
    if (!rst_n) begin
      clear_line();
      answer_q.delete();
      pending_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual pos=%0d ovf=%0b",
                   $time, out_converted_position, out_line_overflowed);
          err_tally++;
        end else begin
          want = answer_q.pop_front();
          lookups++;
          if (out_line_overflowed) ovf_lookups++;
          if (out_converted_position !== want.pos) begin
            $display("%0t: converted_position mismatch, expected %0d, actual %0d", $time,
                     want.pos, out_converted_position);
            err_tally++;
          end
          if (out_line_overflowed !== want.ovf) begin
            $display("%0t: line_overflowed mismatch, expected %0b, actual %0b", $time,
                     want.ovf, out_line_overflowed);
            err_tally++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_action)
          ACT_NEW_LINE: clear_line();
          ACT_BYTE:     absorb_text_byte(in_text_byte);
          default: begin
            want.pos = convert_position(in_action == ACT_POINT_TO_UNIT, in_query_position);
            want.ovf = line_dropped;
            answer_q.push_back(want);
          end
        endcase
      end
      pending_count <= answer_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the UTF-8 line position mapper. A short directed
// line covers every byte class and the clamping of lookups. Two full-capacity
// lines follow: one ends in a truncated four-byte lead, and both run past the
// capacity. Many short random lines come next, mostly well-formed, with some
// noise and broken sequences. Lookups are mixed in across four sender and
// receiver pressure profiles. line_position_checker does all of the checking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ulpm_pkg::*;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = ACT_NEW_LINE;
  logic [7:0]         in_text_byte = '0;
  logic signed [15:0] in_query_position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [12:0]        out_converted_position;
  logic               out_line_overflowed;

  int error_count;
  int pending_count;
  int lookup_count;
  int overflow_lookups;
  int idle_pct = 0;
  int stall_pct = 0;
  int beat_count = 0;
  int line_count = 0;

  utf8_line_position_mapper dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_text_byte           (in_text_byte),
    .in_query_position      (in_query_position),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_converted_position (out_converted_position),
    .out_line_overflowed    (out_line_overflowed)
  );

  line_position_checker checker_i (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_text_byte           (in_text_byte),
    .in_query_position      (in_query_position),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_converted_position (out_converted_position),
    .out_line_overflowed    (out_line_overflowed),
    .error_count            (error_count),
    .pending_count          (pending_count),
    .lookup_count           (lookup_count),
    .overflow_lookups       (overflow_lookups)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  initial begin
    #12_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_beat(input logic [1:0] act, input logic [7:0] b, input logic [15:0] q);
    while ((idle_pct != 0) && ($urandom_range(99) < idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= act;
    in_text_byte      <= b;
    in_query_position <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beat_count++;
  endtask

  task automatic begin_line();
    send_beat(ACT_NEW_LINE, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)));
    line_count++;
  endtask

  // position mostly near the line span, sometimes negative or anywhere
  task automatic random_lookup(input int span);
    logic [1:0]  act;
    logic [15:0] q;
    int          roll;
    act  = $urandom_range(1) ? ACT_POINT_TO_UNIT : ACT_UNIT_TO_POINT;
    roll = $urandom_range(99);
    if (roll < 70) q = 16'($urandom_range(span + 2));
    else if (roll < 80) q = 16'(span + $urandom_range(1));
    else if (roll < 90) q = 16'h8000 | 16'($urandom_range(16'h7FFF));
    else q = 16'($urandom_range(16'hFFFF));
    send_beat(act, 8'($urandom_range(255)), q);
  endtask

  task automatic drain_results();
    do @(posedge clk); while (pending_count != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_line(input int max_bytes);
    int         nb;
    int         sent;
    int         kind;
    int         ncont;
    int         roll;
    logic [7:0] lead;
    begin_line();
    nb   = $urandom_range(max_bytes);
    sent = 0;
    while (sent < nb) begin
      roll = $urandom_range(99);
      kind = $urandom_range(3);
      if (roll >= 92 && kind == 0) kind = 1;
      case (kind)
        0:       lead = 8'($urandom_range(8'h7F));
        1:       lead = 8'hC0 | 8'($urandom_range(8'h1F));
        2:       lead = 8'hE0 | 8'($urandom_range(8'h0F));
        default: lead = 8'hF0 | 8'($urandom_range(8'h07));
      endcase
      ncont = kind;
      if (roll >= 82 && roll < 92) begin
        lead  = 8'($urandom_range(255));
        ncont = 0;
      end else if (roll >= 92) begin
        ncont = $urandom_range(kind - 1);
      end
      send_beat(ACT_BYTE, lead, 16'($urandom_range(16'hFFFF)));
      sent++;
      repeat (ncont) begin
        send_beat(ACT_BYTE, 8'h80 | 8'($urandom_range(8'h3F)), 16'($urandom_range(16'hFFFF)));
        sent++;
      end
      if ($urandom_range(99) < 25) random_lookup(sent);
    end
    repeat ($urandom_range(1, 3)) random_lookup(sent);
  endtask

  // full-capacity line, then a few dropped beats
  task automatic long_line(input bit four_tail);
    int         sent;
    logic [7:0] b;
    begin_line();
    sent = 0;
    while (sent < MAX_LINE_BYTES + 6) begin
      if (four_tail)
        b = (sent == MAX_LINE_BYTES - 1) ? 8'hF0 : 8'($urandom_range(8'h7F));
      else
        b = 8'($urandom_range(255));
      send_beat(ACT_BYTE, b, 16'($urandom_range(16'hFFFF)));
      sent++;
      if ($urandom_range(99) < 2) random_lookup(sent);
    end
    if (four_tail) begin
      send_beat(ACT_UNIT_TO_POINT, 8'h00, 16'(MAX_LINE_BYTES));
      send_beat(ACT_UNIT_TO_POINT, 8'h00, 16'(MAX_LINE_BYTES + 1));
      send_beat(ACT_POINT_TO_UNIT, 8'h00, 16'(MAX_LINE_BYTES - 1));
      send_beat(ACT_POINT_TO_UNIT, 8'h00, 16'(MAX_LINE_BYTES));
    end
    repeat (4) random_lookup(sent);
  endtask

  initial begin
    int random_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // lookups on the empty line left by reset
    send_beat(ACT_POINT_TO_UNIT, 8'h00, 16'd0);
    send_beat(ACT_UNIT_TO_POINT, 8'hFF, 16'd0);
    begin_line();
    // ascii extremes, 2/3/4-byte sequences, stray and invalid bytes, swallowed ascii
    send_beat(ACT_BYTE, 8'h00, 16'h0000);
    send_beat(ACT_BYTE, 8'h7F, 16'hFFFF);
    send_beat(ACT_BYTE, 8'hC3, 16'h0000);
    send_beat(ACT_BYTE, 8'hA9, 16'h0000);
    send_beat(ACT_BYTE, 8'hE2, 16'h0000);
    send_beat(ACT_BYTE, 8'h82, 16'h0000);
    send_beat(ACT_BYTE, 8'hAC, 16'h0000);
    send_beat(ACT_BYTE, 8'hF0, 16'h0000);
    send_beat(ACT_BYTE, 8'h9F, 16'h0000);
    send_beat(ACT_BYTE, 8'h98, 16'h0000);
    send_beat(ACT_BYTE, 8'h80, 16'h0000);
    send_beat(ACT_BYTE, 8'h80, 16'h0000);
    send_beat(ACT_BYTE, 8'hFF, 16'h0000);
    send_beat(ACT_BYTE, 8'hF8, 16'h0000);
    send_beat(ACT_BYTE, 8'hC0, 16'h0000);
    send_beat(ACT_BYTE, 8'h41, 16'h0000);
    send_beat(ACT_POINT_TO_UNIT, 8'h00, 16'h8000);
    send_beat(ACT_POINT_TO_UNIT, 8'h00, 16'h7FFF);
    send_beat(ACT_UNIT_TO_POINT, 8'h00, 16'hFFFF);
    send_beat(ACT_UNIT_TO_POINT, 8'h00, 16'd5);
    send_beat(ACT_UNIT_TO_POINT, 8'h00, 16'd10);
    send_beat(ACT_POINT_TO_UNIT, 8'h00, 16'd4);
    in_valid <= 1'b0;
    drain_results();

    long_line(1'b1);
    idle_pct  = 38;
    stall_pct = 38;
    long_line(1'b0);
    in_valid <= 1'b0;
    drain_results();

    random_start = beat_count;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 72; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      while (beat_count - random_start < (phase + 1) * 375) random_line(40);
      in_valid <= 1'b0;
      drain_results();
    end

    $display("Run covered %0d beats over %0d lines, %0d lookups checked (%0d on overflowed lines)",
             beat_count, line_count, lookup_count, overflow_lookups);
    $display("Pressure: free-running, sender 72%% idle, receiver 72%% stall, both 38%%");
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ulpm_pkg.sv
sv/ulpm_ctrl.sv
sv/ulpm_dp.sv
sv/utf8_line_position_mapper.sv
test/line_position_checker.sv
test/tb_top.sv
